>>> design/sldr_pkg.sv
// Package: payload types, command codes and pipeline constants for the divide/remainder/multiply unit.
`default_nettype none
package sldr_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned NumStages = DataW;  // one quotient bit per stage
  localparam int unsigned DigW = 16;          // multiplier digit width
  localparam int unsigned NumDig = DataW / DigW;

  typedef enum logic [1:0] {
    CMD_DIV = 2'd0,
    CMD_REM = 2'd1,
    CMD_MUL = 2'd2,
    CMD_NOP = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DataW-1:0]  operand_a;
    logic [DataW-1:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0]  result_value;
    logic              divide_by_zero;
  } out_item_t;

  // Per-item control that travels beside the division datapath.
  typedef struct packed {
    logic [1:0] cmd;
    logic       neg_q;
    logic       neg_r;
    logic       dz;
  } ctl_t;

  // Divider lane state: partial remainder, dividend shift register, divisor.
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] dvs;
  } div_lane_t;

  // Multiplier lane: 16-bit-digit partial products of the low 64 bits.
  typedef struct packed {
    logic [DataW-1:0] acc;
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
  } mul_lane_t;

endpackage
`default_nettype wire

>>> design/sldr_div_stage.sv
// One restoring-division step: shift one dividend bit in, compare, subtract.
`default_nettype none
module sldr_div_stage
  import sldr_pkg::*;
(
  input  wire div_lane_t  lane_i,
  output div_lane_t       lane_o
);

  logic [DataW:0] rem_sh;
  logic [DataW:0] diff;

  always_comb begin
    rem_sh = {lane_i.rem, lane_i.quo[DataW-1]};
    diff   = rem_sh - {1'b0, lane_i.dvs};
    lane_o.dvs = lane_i.dvs;
    if (!diff[DataW]) begin
      lane_o.rem = diff[DataW-1:0];
      lane_o.quo = {lane_i.quo[DataW-2:0], 1'b1};
    end else begin
      lane_o.rem = rem_sh[DataW-1:0];
      lane_o.quo = {lane_i.quo[DataW-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

>>> design/signed_long_div_rem_mul_unit_core.sv
// Top level: pipelined signed 64-bit divide, remainder and low-product multiply.
// Throughput: one transfer per cycle; busy is held low, the receiver cannot stall.
// The depth is set by the 64 restoring-division steps, one register stage each.
// Multiply rides the same pipe: four 16-bit digit passes, then the product waits.
// Reset (rst_n low, synchronous) clears every valid bit; payload is left as is.
`default_nettype none
module signed_long_div_rem_mul_unit_core
  import sldr_pkg::*;
(
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  wire in_item_t   in_item,
  output logic            out_valid,
  output out_item_t       out_item
);

  // Never stalls: every stage advances every cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // Stage 0: take magnitudes, signs and the zero-divisor flag.
  logic      v0_r;
  div_lane_t d0_r;
  ctl_t      c0_r;
  mul_lane_t m0_r;

  logic a_neg, b_neg;
  logic [DataW-1:0] mag_a, mag_b;
  always_comb begin
    a_neg = in_item.operand_a[DataW-1];
    b_neg = in_item.operand_b[DataW-1];
    mag_a = a_neg ? (~in_item.operand_a + 1'b1) : in_item.operand_a;
    mag_b = b_neg ? (~in_item.operand_b + 1'b1) : in_item.operand_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    d0_r.rem <= '0;
    d0_r.quo <= mag_a;
    d0_r.dvs <= mag_b;
    c0_r.cmd   <= in_item.cmd;
    c0_r.neg_q <= a_neg ^ b_neg;
    c0_r.neg_r <= a_neg;
    c0_r.dz    <= (in_item.operand_b == '0);
    m0_r.acc <= '0;
    m0_r.a   <= in_item.operand_a;
    m0_r.b   <= in_item.operand_b;
  end

  // Division steps, one per stage; control and multiply lanes advance beside them.
  logic      v_r [NumStages+1];
  div_lane_t d_r [NumStages+1];
  ctl_t      c_r [NumStages+1];
  mul_lane_t m_r [NumStages+1];

  always_comb begin
    v_r[0] = v0_r;
    d_r[0] = d0_r;
    c_r[0] = c0_r;
    m_r[0] = m0_r;
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    div_lane_t lane_nxt;
    mul_lane_t mul_nxt;
    logic      v_hold_r;
    div_lane_t d_hold_r;
    ctl_t      c_hold_r;
    mul_lane_t m_hold_r;

    sldr_div_stage u_step (
      .lane_i (d_r[s]),
      .lane_o (lane_nxt)
    );

    // Fold one 16-bit digit of b into the product in the first stages.
    always_comb begin
      mul_nxt = m_r[s];
      if (s < NumDig) begin
        mul_nxt.acc = m_r[s].acc
                    + ((m_r[s].a * {{(DataW-DigW){1'b0}}, m_r[s].b[DigW-1:0]})
                       << (s * DigW));
        mul_nxt.b   = m_r[s].b >> DigW;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_hold_r <= 1'b0;
      end else begin
        v_hold_r <= v_r[s];
      end
      d_hold_r <= lane_nxt;
      c_hold_r <= c_r[s];
      m_hold_r <= mul_nxt;
    end

    always_comb begin
      v_r[s+1] = v_hold_r;
      d_r[s+1] = d_hold_r;
      c_r[s+1] = c_hold_r;
      m_r[s+1] = m_hold_r;
    end
  end

  // Final stages: apply signs, then select the result.
  logic             vf_r;
  ctl_t             cf_r;
  logic [DataW-1:0] qf_r, rf_r, pf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else begin
      vf_r <= v_r[NumStages];
    end
    cf_r <= c_r[NumStages];
    qf_r <= c_r[NumStages].neg_q ? (~d_r[NumStages].quo + 1'b1) : d_r[NumStages].quo;
    rf_r <= c_r[NumStages].neg_r ? (~d_r[NumStages].rem + 1'b1) : d_r[NumStages].rem;
    pf_r <= m_r[NumStages].acc;
  end

  out_item_t res_nxt;
  always_comb begin
    res_nxt = '0;
    case (cmd_t'(cf_r.cmd))
      CMD_DIV: begin
        res_nxt.divide_by_zero = cf_r.dz;
        res_nxt.result_value   = cf_r.dz ? '0 : qf_r;
      end
      CMD_REM: begin
        res_nxt.divide_by_zero = cf_r.dz;
        res_nxt.result_value   = cf_r.dz ? '0 : rf_r;
      end
      CMD_MUL: res_nxt.result_value = pf_r;
      default: res_nxt = '0;
    endcase
  end

  logic      out_valid_r;
  out_item_t out_item_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vf_r;
    end
    out_item_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A transfer held in stage 0 always reaches the output as an out_valid strobe.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> ##(NumStages+2) out_valid)
    else $error("result strobe lost");

  a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.divide_by_zero |-> out_item.result_value == '0)
    else $error("zero divisor with nonzero result");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("unexpected stall");

endmodule
`default_nettype wire
